// File: sv/eppc_pkg.sv
// eppc_pkg: shared types and constants for the encoder position controller
// register indexes, reset values and control structs
// no dependencies
package eppc_pkg;

    localparam int IdxW     = 3;
    localparam int GainW    = 16;
    localparam int FracBits = 4;

    localparam logic [IdxW-1:0] REG_TARGET   = 3'd0;
    localparam logic [IdxW-1:0] REG_GAIN     = 3'd1;
    localparam logic [IdxW-1:0] REG_PERIOD   = 3'd2;
    localparam logic [IdxW-1:0] REG_INTERVAL = 3'd3;
    localparam logic [IdxW-1:0] REG_ENABLE   = 3'd4;

    localparam int RstTarget   = 30;
    localparam int RstGain     = 1280;
    localparam int RstPeriod   = 5000;
    localparam int RstInterval = 10000;

    typedef struct packed {
        logic enc_a;
        logic enc_b;
    } sample_t;

    typedef struct packed {
        logic en;
        logic upd;
        logic per_start;
    } tick_ctl_t;

endpackage

// File: sv/eppc_if.sv
// eppc_if: valid/ready channels for encoder samples and controller results
// depends on nothing
interface eppc_sample_if;
    logic valid;
    logic ready;
    logic enc_a;
    logic enc_b;

    modport source (output valid, output enc_a, output enc_b, input ready);
    modport sink (input valid, input enc_a, input enc_b, output ready);
endinterface

interface eppc_result_if #(
    parameter int POSITION_BITS = 24
);
    logic                            valid;
    logic                            ready;
    logic                            drive_high;
    logic                            direction;
    logic signed [POSITION_BITS-1:0] position;

    modport source (output valid, output drive_high, output direction, output position,
                    input ready);
    modport sink (input valid, input drive_high, input direction, input position,
                  output ready);
endinterface

// File: sv/encoder_position_p_controller_pwm_core.sv
// encoder_position_p_controller_pwm_core: encoder count, proportional law and pwm drive
// depends on eppc_pkg, eppc_if and eppc_encoder
// throughput: one item per cycle; ready is high while the output register is empty or taken
// stages: input reg, encoder and timers, error subtract, 25x16 multiply, saturate/latch/compare
// reset: async low clears the pipeline, counters and command state, and loads register defaults
module encoder_position_p_controller_pwm_core #(
    parameter int POSITION_BITS = 24,
    parameter int TIMER_BITS    = 16,
    localparam int CfgW = (POSITION_BITS > TIMER_BITS)
        ? ((POSITION_BITS > eppc_pkg::GainW) ? POSITION_BITS : eppc_pkg::GainW)
        : ((TIMER_BITS > eppc_pkg::GainW) ? TIMER_BITS : eppc_pkg::GainW)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    eppc_sample_if.sink                   sample,
    eppc_result_if.source                 result,
    input  logic                          wr_en,
    input  logic [eppc_pkg::IdxW-1:0]     wr_index,
    input  logic [CfgW-1:0]               wr_data
);

    localparam int ProdW = POSITION_BITS + 1 + eppc_pkg::GainW;
    localparam int MagW  = ProdW - eppc_pkg::FracBits;
    localparam int WideW = (MagW > TIMER_BITS) ? MagW : TIMER_BITS;

    // configuration registers
    logic signed [POSITION_BITS-1:0]   target_reg;
    logic [eppc_pkg::GainW-1:0]        gain_reg;
    logic [TIMER_BITS-1:0]             period_reg;
    logic [TIMER_BITS-1:0]             interval_reg;
    logic                              enable_reg;
    logic [TIMER_BITS-1:0]             per_eff;
    logic [TIMER_BITS-1:0]             itv_eff;

    logic advance;
    logic step;

    // stage 1
    logic                              s1_valid_reg;
    eppc_pkg::sample_t                 s1_smp_reg;
    logic [TIMER_BITS-1:0]             uc_reg;
    logic [TIMER_BITS-1:0]             uc_next;
    logic [TIMER_BITS-1:0]             pc_reg;
    logic [TIMER_BITS-1:0]             pc_next;
    logic [TIMER_BITS:0]               uc_inc;
    logic [TIMER_BITS:0]               pc_inc;
    eppc_pkg::tick_ctl_t               s1_ctl;
    logic signed [POSITION_BITS-1:0]   count_next;
    logic signed [POSITION_BITS-1:0]   enc_count;

    // stage 2
    logic                              s2_valid_reg;
    eppc_pkg::tick_ctl_t               s2_ctl_reg;
    logic [TIMER_BITS-1:0]             s2_pc_reg;
    logic signed [POSITION_BITS-1:0]   s2_pos_reg;
    logic signed [POSITION_BITS:0]     err;
    logic                              err_neg;
    logic [POSITION_BITS:0]            err_mag;

    // stage 3
    logic                              s3_valid_reg;
    eppc_pkg::tick_ctl_t               s3_ctl_reg;
    logic [TIMER_BITS-1:0]             s3_pc_reg;
    logic signed [POSITION_BITS-1:0]   s3_pos_reg;
    logic [POSITION_BITS:0]            s3_mag_reg;
    logic                              s3_neg_reg;
    logic [ProdW-1:0]                  prod;

    // stage 4
    logic                              s4_valid_reg;
    eppc_pkg::tick_ctl_t               s4_ctl_reg;
    logic [TIMER_BITS-1:0]             s4_pc_reg;
    logic signed [POSITION_BITS-1:0]   s4_pos_reg;
    logic [ProdW-1:0]                  s4_prod_reg;
    logic                              s4_neg_reg;
    logic [WideW-1:0]                  mag_w;
    logic [TIMER_BITS-1:0]             mag_sat;

    // command and pwm state
    logic [TIMER_BITS-1:0]             cmd_mag_reg;
    logic [TIMER_BITS-1:0]             cmd_mag_next;
    logic                              cmd_neg_reg;
    logic                              cmd_neg_next;
    logic [TIMER_BITS-1:0]             duty_reg;
    logic [TIMER_BITS-1:0]             duty_next;
    logic                              dir_reg;
    logic                              dir_next;
    logic                              drive_next;

    // output register
    logic                              out_valid_reg;
    logic                              out_drive_reg;
    logic signed [POSITION_BITS-1:0]   out_pos_reg;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= POSITION_BITS'(eppc_pkg::RstTarget);
            gain_reg     <= eppc_pkg::GainW'(eppc_pkg::RstGain);
            period_reg   <= TIMER_BITS'(eppc_pkg::RstPeriod);
            interval_reg <= TIMER_BITS'(eppc_pkg::RstInterval);
            enable_reg   <= 1'b1;
        end
        else if (wr_en)
        begin
            case (wr_index)
                eppc_pkg::REG_TARGET:   target_reg   <= wr_data[POSITION_BITS-1:0];
                eppc_pkg::REG_GAIN:     gain_reg     <= wr_data[eppc_pkg::GainW-1:0];
                eppc_pkg::REG_PERIOD:   period_reg   <= wr_data[TIMER_BITS-1:0];
                eppc_pkg::REG_INTERVAL: interval_reg <= wr_data[TIMER_BITS-1:0];
                eppc_pkg::REG_ENABLE:   enable_reg   <= wr_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign per_eff = (period_reg == '0) ? TIMER_BITS'(1) : period_reg;
    assign itv_eff = (interval_reg == '0) ? TIMER_BITS'(1) : interval_reg;

    // global stall: everything moves when the output register is free
    assign advance      = !out_valid_reg || result.ready;
    assign sample.ready = advance;
    assign step         = advance && s1_valid_reg;

    // stage 1: encoder and timers
    eppc_encoder #(
        .POSITION_BITS (POSITION_BITS)
    ) u_encoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .smp        (s1_smp_reg),
        .count_next (count_next),
        .count      (enc_count)
    );

    always_comb
    begin
        uc_inc           = {1'b0, uc_reg} + (TIMER_BITS + 1)'(1);
        pc_inc           = {1'b0, pc_reg} + (TIMER_BITS + 1)'(1);
        s1_ctl.en        = enable_reg;
        s1_ctl.upd       = enable_reg && (uc_reg == '0);
        s1_ctl.per_start = enable_reg && (pc_reg == '0);
        uc_next          = uc_reg;
        pc_next          = pc_reg;
        if (step)
        begin
            if (enable_reg)
            begin
                uc_next = (uc_inc >= {1'b0, itv_eff}) ? '0 : uc_inc[TIMER_BITS-1:0];
                pc_next = (pc_inc >= {1'b0, per_eff}) ? '0 : pc_inc[TIMER_BITS-1:0];
            end
            else
            begin
                uc_next = '0;
                pc_next = '0;
            end
        end
    end

    // stage 2: position error
    always_comb
    begin
        err     = {target_reg[POSITION_BITS-1], target_reg}
                - {s2_pos_reg[POSITION_BITS-1], s2_pos_reg};
        err_neg = err[POSITION_BITS];
        err_mag = err_neg ? (~err + (POSITION_BITS + 1)'(1)) : err;
    end

    // stage 3: gain multiply
    assign prod = ProdW'(s3_mag_reg) * ProdW'(gain_reg);

    // stage 4: saturate, period latch and pwm compare
    always_comb
    begin
        mag_w        = WideW'(s4_prod_reg[ProdW-1:eppc_pkg::FracBits]);
        mag_sat      = (mag_w > WideW'({TIMER_BITS{1'b1}})) ? {TIMER_BITS{1'b1}}
                                                             : mag_w[TIMER_BITS-1:0];
        cmd_mag_next = cmd_mag_reg;
        cmd_neg_next = cmd_neg_reg;
        if (s4_ctl_reg.upd)
        begin
            cmd_neg_next = s4_neg_reg && (|s4_prod_reg);
            cmd_mag_next = mag_sat;
        end
        duty_next = duty_reg;
        dir_next  = dir_reg;
        if (s4_ctl_reg.per_start)
        begin
            dir_next  = !cmd_neg_next;
            duty_next = (cmd_mag_next > per_eff) ? per_eff : cmd_mag_next;
        end
        drive_next = s4_ctl_reg.en && (s4_pc_reg < duty_next);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            uc_reg        <= '0;
            pc_reg        <= '0;
            cmd_mag_reg   <= '0;
            cmd_neg_reg   <= 1'b0;
            duty_reg      <= '0;
            dir_reg       <= 1'b1;
        end
        else
        begin
            uc_reg <= uc_next;
            pc_reg <= pc_next;
            if (advance)
            begin
                s1_valid_reg  <= sample.valid;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                out_valid_reg <= s4_valid_reg;
                if (s4_valid_reg)
                begin
                    cmd_mag_reg <= cmd_mag_next;
                    cmd_neg_reg <= cmd_neg_next;
                    duty_reg    <= duty_next;
                    dir_reg     <= dir_next;
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_smp_reg    <= '{enc_a: sample.enc_a, enc_b: sample.enc_b};
            s2_ctl_reg    <= s1_ctl;
            s2_pc_reg     <= pc_reg;
            s2_pos_reg    <= count_next;
            s3_ctl_reg    <= s2_ctl_reg;
            s3_pc_reg     <= s2_pc_reg;
            s3_pos_reg    <= s2_pos_reg;
            s3_mag_reg    <= err_mag;
            s3_neg_reg    <= err_neg;
            s4_ctl_reg    <= s3_ctl_reg;
            s4_pc_reg     <= s3_pc_reg;
            s4_pos_reg    <= s3_pos_reg;
            s4_prod_reg   <= prod;
            s4_neg_reg    <= s3_neg_reg;
            out_drive_reg <= drive_next;
            out_pos_reg   <= s4_pos_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.drive_high = out_drive_reg;
    assign result.direction  = dir_reg;
    assign result.position   = out_pos_reg;

    // a driven output needs a nonzero latched duty
    a_drive_needs_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.drive_high) |-> (duty_reg != '0))
        else $error("drive high with zero duty");

    // disabled ticks park both timers at zero
    a_disable_clears_timers: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !enable_reg) |=> ((uc_reg == '0) && (pc_reg == '0)))
        else $error("timers not cleared while disabled");

    // the error stage sees the count the encoder holds
    a_pos_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_pos_reg == enc_count))
        else $error("pipelined position differs from encoder count");

endmodule

// File: sv/eppc_encoder.sv
// eppc_encoder: channel A rising edge detect and saturating position counter
// depends on eppc_pkg
module eppc_encoder #(
    parameter int POSITION_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  eppc_pkg::sample_t               smp,
    output logic signed [POSITION_BITS-1:0] count_next,
    output logic signed [POSITION_BITS-1:0] count
);

    localparam logic signed [POSITION_BITS-1:0] PosMax = {1'b0, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [POSITION_BITS-1:0] PosMin = {1'b1, {(POSITION_BITS-1){1'b0}}};

    logic                            last_a_reg;
    logic                            last_a_next;
    logic signed [POSITION_BITS-1:0] count_reg;
    logic                            rise;

    always_comb
    begin
        rise        = step && smp.enc_a && !last_a_reg;
        last_a_next = step ? smp.enc_a : last_a_reg;
        count_next  = count_reg;
        if (rise)
        begin
            if (!smp.enc_b)
            begin
                if (count_reg != PosMin)
                begin
                    count_next = count_reg - POSITION_BITS'(1);
                end
            end
            else
            begin
                if (count_reg != PosMax)
                begin
                    count_next = count_reg + POSITION_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_a_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            last_a_reg <= last_a_next;
            count_reg  <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// File: tb/sv/eppc_tick_checker.sv
`timescale 1ns / 1ps
// eppc_tick_checker: watches sample, result and register write traffic of the encoder
// position controller, models every tick and compares each result field by field
// depends on eppc_pkg and eppc_if
module eppc_tick_checker #(
    parameter int POSITION_BITS = 24,
    parameter int TIMER_BITS    = 16,
    parameter int CfgW          = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    eppc_sample_if                        sample,
    eppc_result_if                        result,
    input  logic                          wr_en,
    input  logic [eppc_pkg::IdxW-1:0]     wr_index,
    input  logic [CfgW-1:0]               wr_data,
    output int                            mismatch_count,
    output int                            ticks_in_flight
);

    typedef struct packed {
        logic                            drive_high;
        logic                            direction;
        logic signed [POSITION_BITS-1:0] position;
    } tick_out_t;

    localparam logic signed [POSITION_BITS-1:0] PosMax = {1'b0, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [POSITION_BITS-1:0] PosMin = {1'b1, {(POSITION_BITS-1){1'b0}}};
    localparam logic [TIMER_BITS-1:0] TmrMax = '1;

    logic signed [POSITION_BITS-1:0] target_reg;
    logic [eppc_pkg::GainW-1:0]      gain_reg;
    logic [TIMER_BITS-1:0]           period_reg;
    logic [TIMER_BITS-1:0]           interval_reg;
    logic                            enable_reg;

    logic                            prev_a;
    logic signed [POSITION_BITS-1:0] count;
    logic [TIMER_BITS-1:0]           cmd_mag;
    logic                            cmd_neg;
    logic [TIMER_BITS-1:0]           duty;
    logic                            dir;
    logic [TIMER_BITS-1:0]           period_cnt;
    logic [TIMER_BITS-1:0]           update_cnt;

    tick_out_t tick_outputs_q[$];

    // gain is q12.4, product truncated toward zero, sign kept apart
    task automatic update_command();
        longint err;
        longint err_mag;
        longint prod;
        err = longint'(target_reg) - longint'(count);
        err_mag = (err < 0) ? -err : err;
        prod = err_mag * longint'(gain_reg);
        cmd_neg = (err < 0) && (prod != 0);
        cmd_mag = ((prod >> eppc_pkg::FracBits) > longint'(TmrMax))
                ? TmrMax : TIMER_BITS'(prod >> eppc_pkg::FracBits);
    endtask

    task automatic run_control_tick(input logic a, input logic b, output tick_out_t o);
        logic [TIMER_BITS:0] per_len;
        logic [TIMER_BITS:0] itv_len;
        logic                drive;
        drive = 1'b0;
        if (a && !prev_a) begin
            if (!b) begin
                if (count != PosMin)
                    count = count - POSITION_BITS'(1);
            end
            else if (count != PosMax) begin
                count = count + POSITION_BITS'(1);
            end
        end
        prev_a = a;
        if (enable_reg) begin
            per_len = {1'b0, (period_reg == '0) ? TIMER_BITS'(1) : period_reg};
            itv_len = {1'b0, (interval_reg == '0) ? TIMER_BITS'(1) : interval_reg};
            if (update_cnt == '0)
                update_command();
            update_cnt = ({1'b0, update_cnt} + (TIMER_BITS + 1)'(1) >= itv_len)
                       ? '0 : update_cnt + TIMER_BITS'(1);
            if (period_cnt == '0) begin
                dir = !cmd_neg;
                duty = ({1'b0, cmd_mag} > per_len) ? per_len[TIMER_BITS-1:0] : cmd_mag;
            end
            drive = period_cnt < duty;
            period_cnt = ({1'b0, period_cnt} + (TIMER_BITS + 1)'(1) >= per_len)
                       ? '0 : period_cnt + TIMER_BITS'(1);
        end
        else begin
            period_cnt = '0;
            update_cnt = '0;
        end
        o.drive_high = drive;
        o.direction  = dir;
        o.position   = count;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tick_out_t want;
        if (!rst_n) begin
            target_reg   = POSITION_BITS'(eppc_pkg::RstTarget);
            gain_reg     = eppc_pkg::GainW'(eppc_pkg::RstGain);
            period_reg   = TIMER_BITS'(eppc_pkg::RstPeriod);
            interval_reg = TIMER_BITS'(eppc_pkg::RstInterval);
            enable_reg   = 1'b1;
            prev_a       = 1'b0;
            count        = '0;
            cmd_mag      = '0;
            cmd_neg      = 1'b0;
            duty         = '0;
            dir          = 1'b1;
            period_cnt   = '0;
            update_cnt   = '0;
            tick_outputs_q.delete();
            mismatch_count = 0;
            ticks_in_flight <= 0;
        end
        else begin
            if (wr_en) begin
                case (wr_index)
                    eppc_pkg::REG_TARGET:   target_reg   = wr_data[POSITION_BITS-1:0];
                    eppc_pkg::REG_GAIN:     gain_reg     = wr_data[eppc_pkg::GainW-1:0];
                    eppc_pkg::REG_PERIOD:   period_reg   = wr_data[TIMER_BITS-1:0];
                    eppc_pkg::REG_INTERVAL: interval_reg = wr_data[TIMER_BITS-1:0];
                    eppc_pkg::REG_ENABLE:   enable_reg   = wr_data[0];
                    default: ;
                endcase
            end
            if (sample.valid && sample.ready) begin
                run_control_tick(sample.enc_a, sample.enc_b, want);
                tick_outputs_q.push_back(want);
            end
            if (result.valid && result.ready) begin
                if (tick_outputs_q.size() == 0) begin
                    $error("result item with no sample item waiting for it");
                    mismatch_count++;
                end
                else begin
                    want = tick_outputs_q.pop_front();
                    if (result.drive_high !== want.drive_high) begin
                        $error("drive_high: expected %0d, got %0d",
                               want.drive_high, result.drive_high);
                        mismatch_count++;
                    end
                    if (result.direction !== want.direction) begin
                        $error("direction: expected %0d, got %0d",
                               want.direction, result.direction);
                        mismatch_count++;
                    end
                    if (result.position !== want.position) begin
                        $error("position: expected %0d, got %0d",
                               want.position, result.position);
                        mismatch_count++;
                    end
                end
            end
            ticks_in_flight <= tick_outputs_q.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: clock, reset, register setup and quadrature encoder stimulus for the controller core
// depends on eppc_pkg, eppc_if, eppc_tick_checker and encoder_position_p_controller_pwm_core
module tb;

    localparam int PosW      = 24;
    localparam int TmrW      = 16;
    localparam int CfgW      = 24;
    localparam int TickCount = 1600;
    localparam int PosMax    = (1 << (PosW - 1)) - 1;
    localparam int PosMin    = -(1 << (PosW - 1));
    localparam int TmrMax    = (1 << TmrW) - 1;
    localparam int GainMax   = (1 << eppc_pkg::GainW) - 1;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          wr_en;
    logic [eppc_pkg::IdxW-1:0]     wr_index;
    logic [CfgW-1:0]               wr_data;
    int                            mismatch_count;
    int                            ticks_in_flight;
    int                            ticks_sent;
    logic                          src_calm;

    eppc_sample_if sample_ch ();
    eppc_result_if #(.POSITION_BITS(PosW)) result_ch ();

    encoder_position_p_controller_pwm_core #(
        .POSITION_BITS(PosW),
        .TIMER_BITS(TmrW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample_ch),
        .result(result_ch),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data)
    );

    eppc_tick_checker #(
        .POSITION_BITS(PosW),
        .TIMER_BITS(TmrW),
        .CfgW(CfgW)
    ) tick_check (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample_ch),
        .result(result_ch),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data),
        .mismatch_count(mismatch_count),
        .ticks_in_flight(ticks_in_flight)
    );

    always #5 clk = ~clk;

    task automatic send_tick(input logic a, input logic b);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.enc_a <= a;
        sample_ch.enc_b <= b;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        ticks_sent++;
    endtask

    // one full quadrature cycle per edge, each state held a few ticks
    task automatic send_run(input logic up, input int edges);
        logic [1:0] seq [4];
        if (up)
            seq = '{2'b01, 2'b11, 2'b10, 2'b00};
        else
            seq = '{2'b10, 2'b11, 2'b01, 2'b00};
        for (int e = 0; e < edges; e++) begin
            for (int q = 0; q < 4; q++) begin
                repeat ($urandom_range(1, 3)) send_tick(seq[q][1], seq[q][0]);
            end
        end
    endtask

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (ticks_in_flight != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [eppc_pkg::IdxW-1:0] idx,
                             input logic [CfgW-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_setting(input int tgt, input int g, input int per, input int itv,
                                input logic en);
        if ($urandom_range(0, 3) == 0)
            write_reg(eppc_pkg::IdxW'($urandom_range(int'(eppc_pkg::REG_ENABLE) + 1,
                                                     (1 << eppc_pkg::IdxW) - 1)),
                      CfgW'($urandom));
        write_reg(eppc_pkg::REG_TARGET, CfgW'(tgt));
        write_reg(eppc_pkg::REG_GAIN, CfgW'(g));
        write_reg(eppc_pkg::REG_PERIOD, CfgW'(per));
        write_reg(eppc_pkg::REG_INTERVAL, CfgW'(itv));
        write_reg(eppc_pkg::REG_ENABLE, CfgW'(en));
        wr_en <= 1'b0;
    endtask

    task automatic load_random_setting();
        int tgt;
        int g;
        int per;
        int itv;
        case ($urandom_range(0, 7))
            0: tgt = PosMax;
            1: tgt = PosMin;
            2: tgt = $urandom;
            default: tgt = int'($urandom_range(0, 400)) - 200;
        endcase
        case ($urandom_range(0, 7))
            0: g = 0;
            1: g = GainMax;
            2: g = $urandom_range(0, GainMax);
            default: g = $urandom_range(1, 96);
        endcase
        case ($urandom_range(0, 9))
            0: per = 0;
            1: per = TmrMax;
            2: per = $urandom_range(0, TmrMax);
            default: per = $urandom_range(1, 40);
        endcase
        case ($urandom_range(0, 9))
            0: itv = 0;
            1: itv = TmrMax;
            2: itv = $urandom_range(0, TmrMax);
            default: itv = $urandom_range(1, 60);
        endcase
        load_setting(tgt, g, per, itv, $urandom_range(0, 7) != 0);
    endtask

    initial
    begin
        int stall;
        int left;
        logic calm;
        calm = 1'b0;
        left = 0;
        forever begin
            if (left == 0) begin
                calm = ($urandom_range(0, 2) == 0);
                left = $urandom_range(20, 80);
            end
            left--;
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid) @(posedge clk);
        end
    end

    initial
    begin
        #5_000_000;
        $display("encoder_position_p_controller_pwm_core test failed");
        $finish;
    end

    initial
    begin
        int quota;
        int first;
        rst_n           <= 1'b0;
        wr_en           <= 1'b0;
        wr_index        <= eppc_pkg::REG_TARGET;
        wr_data         <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.enc_a <= 1'b0;
        sample_ch.enc_b <= 1'b0;
        src_calm = 1'b0;
        ticks_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: step down, step up, step down
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        // saturated command, widest period, zero interval
        wait_idle();
        load_setting(PosMax, GainMax, TmrMax, 0, 1'b1);
        repeat (3) send_tick(1'b0, 1'b0);
        // most negative target, zero period
        wait_idle();
        load_setting(PosMin, 1, 0, 1, 1'b1);
        repeat (3) send_tick(1'b0, 1'b1);
        // negative product that truncates to zero magnitude
        wait_idle();
        load_setting(-2, 15, 8, 4, 1'b1);
        repeat (3) send_tick(1'b0, 1'b0);
        // zero gain
        wait_idle();
        load_setting(-5, 0, 1, 1, 1'b1);
        repeat (3) send_tick(1'b0, 1'b0);
        // disabled, encoder still counts
        wait_idle();
        load_setting(20, 64, 10, 3, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        // enable comes back
        wait_idle();
        load_setting(20, 64, 10, 3, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);

        while (ticks_sent < TickCount) begin
            wait_idle();
            load_random_setting();
            src_calm = ($urandom_range(0, 2) == 0);
            quota = $urandom_range(40, 120);
            first = ticks_sent;
            while (ticks_sent - first < quota) begin
                if ($urandom_range(0, 4) != 0)
                    send_run($urandom_range(0, 1), $urandom_range(1, 12));
                else
                    repeat ($urandom_range(1, 6))
                        send_tick($urandom_range(0, 1), $urandom_range(0, 1));
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && ticks_in_flight == 0)
            $display("encoder_position_p_controller_pwm_core test passed");
        else
            $display("encoder_position_p_controller_pwm_core test failed");
        $finish;
    end

endmodule
